FILE: hdl/fall_detector_with_buzzer_alert_core_defines.svh
// Assertion macros for the fall detector with buzzer alert core.
// Included by the top level; needs no other file.
`ifndef FALL_DETECTOR_WITH_BUZZER_ALERT_CORE_DEFINES_SVH
`define FALL_DETECTOR_WITH_BUZZER_ALERT_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FDBA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication, checked outside reset.
`define FDBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

FILE: hdl/fdba_pkg.sv
// Shared types, codes and pattern tables for the fall detector core.
// Used by every module of the block; depends on nothing.
package fdba_pkg;

   localparam int TIME_BITS         = 32;
   localparam int MAX_PATTERN_STEPS = 6;

   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_ALARM  = 2'd1;
   localparam logic [1:0] MODE_REMIND = 2'd2;
   localparam logic [1:0] MODE_PING   = 2'd3;

   localparam logic [1:0] CMD_NONE   = 2'd0;
   localparam logic [1:0] CMD_PING   = 2'd1;
   localparam logic [1:0] CMD_REMIND = 2'd2;

   localparam logic [1:0] PAT_ALARM  = 2'd0;
   localparam logic [1:0] PAT_REMIND = 2'd1;
   localparam logic [1:0] PAT_PING   = 2'd2;

   localparam logic [2:0] REG_FREEFALL_LIMIT = 3'd0;
   localparam logic [2:0] REG_IMPACT_LIMIT   = 3'd1;
   localparam logic [2:0] REG_FREEFALL_WIN   = 3'd2;
   localparam logic [2:0] REG_ALARM_DELAY    = 3'd3;
   localparam logic [2:0] REG_SAMPLE_PERIOD  = 3'd4;

   localparam logic [31:0] FREEFALL_LIMIT_RST = 32'd262144;
   localparam logic [31:0] IMPACT_LIMIT_RST   = 32'd26214400;
   localparam logic [15:0] FREEFALL_WIN_RST   = 16'd1000;
   localparam logic [15:0] ALARM_DELAY_RST    = 16'd5000;
   localparam logic [7:0]  SAMPLE_PERIOD_RST  = 8'd20;

   localparam logic [7:0] STEP_MS [0:2][0:7] = '{
      '{8'd0, 8'd50,  8'd0,   8'd0,   8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd0, 8'd100, 8'd200, 8'd100, 8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd0, 8'd30,  8'd0,   8'd0,   8'd0, 8'd0, 8'd0, 8'd0}
   };
   localparam logic [3:0] STEP_COUNT [0:2] = '{4'd2, 4'd4, 4'd2};

   typedef struct packed {
      logic [31:0] freefall_limit_sq;
      logic [31:0] impact_limit_sq;
      logic [15:0] freefall_window_ms;
      logic [15:0] alarm_delay_ms;
      logic [7:0]  sample_period_ms;
   } cfg_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] now;
      logic [30:0]          sq_x;
      logic [30:0]          sq_y;
      logic [30:0]          sq_z;
      logic                 reset_pressed;
      logic [1:0]           command;
   } sq_item_type;

   typedef struct packed {
      logic [1:0] alert_mode;
      logic       freefall_flag;
      logic       fall_flag;
      logic       buzzer_on;
   } rsp_item_type;

   function automatic logic [3:0] pattern_len(input logic [1:0] p);
      logic [3:0] n;
      n = STEP_COUNT[p];
      if (n > 4'(MAX_PATTERN_STEPS)) begin
         n = 4'(MAX_PATTERN_STEPS);
      end
      return n;
   endfunction

endpackage

FILE: hdl/fdba_csr.sv
// Configuration register file with an APB-style write and read port.
// Depends on fdba_pkg for the register indexes and reset values.
module fdba_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [4:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output fdba_pkg::cfg_type cfg
);

   fdba_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]        idx;
   logic              wr_en;

   assign idx        = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            fdba_pkg::REG_FREEFALL_LIMIT: cfg_in.freefall_limit_sq  = csr_pwdata;
            fdba_pkg::REG_IMPACT_LIMIT:   cfg_in.impact_limit_sq    = csr_pwdata;
            fdba_pkg::REG_FREEFALL_WIN:   cfg_in.freefall_window_ms = csr_pwdata[15:0];
            fdba_pkg::REG_ALARM_DELAY:    cfg_in.alarm_delay_ms     = csr_pwdata[15:0];
            fdba_pkg::REG_SAMPLE_PERIOD:  cfg_in.sample_period_ms   = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         fdba_pkg::REG_FREEFALL_LIMIT: csr_prdata = cfg_ff.freefall_limit_sq;
         fdba_pkg::REG_IMPACT_LIMIT:   csr_prdata = cfg_ff.impact_limit_sq;
         fdba_pkg::REG_FREEFALL_WIN:   csr_prdata = {16'd0, cfg_ff.freefall_window_ms};
         fdba_pkg::REG_ALARM_DELAY:    csr_prdata = {16'd0, cfg_ff.alarm_delay_ms};
         fdba_pkg::REG_SAMPLE_PERIOD:  csr_prdata = {24'd0, cfg_ff.sample_period_ms};
         default:                      csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.freefall_limit_sq  <= fdba_pkg::FREEFALL_LIMIT_RST;
         cfg_ff.impact_limit_sq    <= fdba_pkg::IMPACT_LIMIT_RST;
         cfg_ff.freefall_window_ms <= fdba_pkg::FREEFALL_WIN_RST;
         cfg_ff.alarm_delay_ms     <= fdba_pkg::ALARM_DELAY_RST;
         cfg_ff.sample_period_ms   <= fdba_pkg::SAMPLE_PERIOD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hdl/fdba_square.sv
// Input register and squaring stage for the three acceleration axes.
// Depends on fdba_pkg for the time width and the stage item type.
module fdba_square (
   input  logic                  clock,
   input  logic                  load_in,
   input  logic                  load_sq,
   input  logic [31:0]           now_ms,
   input  logic signed [15:0]    accel_x,
   input  logic signed [15:0]    accel_y,
   input  logic signed [15:0]    accel_z,
   input  logic                  reset_pressed,
   input  logic [1:0]            command,
   output fdba_pkg::sq_item_type sq_item
);

   logic [fdba_pkg::TIME_BITS-1:0] now_ff;
   logic signed [15:0]             x_ff, y_ff, z_ff;
   logic                           rp_ff;
   logic [1:0]                     cmd_ff;
   logic signed [31:0]             px, py, pz;
   fdba_pkg::sq_item_type          sq_ff, sq_in;

   assign px = x_ff * x_ff;
   assign py = y_ff * y_ff;
   assign pz = z_ff * z_ff;

   always_comb begin
      sq_in.now           = now_ff;
      sq_in.sq_x          = px[30:0];
      sq_in.sq_y          = py[30:0];
      sq_in.sq_z          = pz[30:0];
      sq_in.reset_pressed = rp_ff;
      sq_in.command       = cmd_ff;
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         now_ff <= now_ms[fdba_pkg::TIME_BITS-1:0];
         x_ff   <= accel_x;
         y_ff   <= accel_y;
         z_ff   <= accel_z;
         rp_ff  <= reset_pressed;
         cmd_ff <= command;
      end
      if (load_sq) begin
         sq_ff <= sq_in;
      end
   end

   assign sq_item = sq_ff;

endmodule

FILE: hdl/fdba_tracker.sv
// Fall tracking state, buzzer pattern sequencer and result register.
// Depends on fdba_pkg for codes, tables and item types.
module fdba_tracker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  fdba_pkg::sq_item_type  sq_item,
   input  fdba_pkg::cfg_type      cfg,
   output fdba_pkg::rsp_item_type rsp_item
);

   localparam int TB = fdba_pkg::TIME_BITS;

   logic [TB-1:0] last_sample_ff, last_sample_in;
   logic [TB-1:0] last_ff_time_ff, last_ff_time_in;
   logic [TB-1:0] fall_time_ff, fall_time_in;
   logic          in_freefall_ff, in_freefall_in;
   logic          has_fallen_ff, has_fallen_in;
   logic [1:0]    mode_ff, mode_in;
   logic [2:0]    step_ff [0:2];
   logic [2:0]    step_in [0:2];
   logic [TB-1:0] toggle_ff [0:2];
   logic [TB-1:0] toggle_in [0:2];
   logic          buzzer_ff, buzzer_in;
   fdba_pkg::rsp_item_type rsp_ff, rsp_in;

   always_comb begin
      logic [TB-1:0] now;
      logic [31:0]   mag;
      logic [1:0]    p;
      logic          active;
      logic [2:0]    st;
      logic [3:0]    nxt;
      logic [7:0]    iv;

      now = sq_item.now;
      mag = {1'b0, sq_item.sq_x} + {1'b0, sq_item.sq_y} + {1'b0, sq_item.sq_z};

      last_sample_in  = last_sample_ff;
      last_ff_time_in = last_ff_time_ff;
      fall_time_in    = fall_time_ff;
      in_freefall_in  = in_freefall_ff;
      has_fallen_in   = has_fallen_ff;
      mode_in         = mode_ff;
      buzzer_in       = buzzer_ff;
      for (int i = 0; i < 3; i++) begin
         step_in[i]   = step_ff[i];
         toggle_in[i] = toggle_ff[i];
      end

      case (sq_item.command)
         fdba_pkg::CMD_PING: begin
            step_in[fdba_pkg::PAT_PING] = 3'd0;
            mode_in = fdba_pkg::MODE_PING;
         end
         fdba_pkg::CMD_REMIND: begin
            step_in[fdba_pkg::PAT_REMIND] = 3'd0;
            mode_in = fdba_pkg::MODE_REMIND;
         end
         default: ;
      endcase

      if (TB'(now - last_sample_ff) > {{(TB-8){1'b0}}, cfg.sample_period_ms}) begin
         last_sample_in = now;
         if (mag < cfg.freefall_limit_sq) begin
            in_freefall_in  = 1'b1;
            last_ff_time_in = now;
         end
         if (TB'(now - last_ff_time_in) > {{(TB-16){1'b0}}, cfg.freefall_window_ms}) begin
            in_freefall_in = 1'b0;
         end
         if (in_freefall_in && (mag > cfg.impact_limit_sq)) begin
            has_fallen_in  = 1'b1;
            in_freefall_in = 1'b0;
            fall_time_in   = now;
            step_in[fdba_pkg::PAT_PING] = 3'd0;
            mode_in = fdba_pkg::MODE_PING;
         end
      end

      if (has_fallen_in &&
          (TB'(now - fall_time_in) > {{(TB-16){1'b0}}, cfg.alarm_delay_ms})) begin
         mode_in = fdba_pkg::MODE_ALARM;
      end else if (mode_in == fdba_pkg::MODE_ALARM) begin
         mode_in   = fdba_pkg::MODE_IDLE;
         buzzer_in = 1'b0;
      end

      active = 1'b1;
      case (mode_in)
         fdba_pkg::MODE_ALARM:  p = fdba_pkg::PAT_ALARM;
         fdba_pkg::MODE_REMIND: p = fdba_pkg::PAT_REMIND;
         fdba_pkg::MODE_PING:   p = fdba_pkg::PAT_PING;
         default: begin
            p      = fdba_pkg::PAT_ALARM;
            active = 1'b0;
         end
      endcase

      st  = step_in[p];
      iv  = ({1'b0, st} < fdba_pkg::pattern_len(p)) ? fdba_pkg::STEP_MS[p][st] : 8'd0;
      nxt = {1'b0, st} + 4'd1;

      if (!active) begin
         buzzer_in = 1'b0;
      end else if (TB'(now - toggle_in[p]) >= {{(TB-8){1'b0}}, iv}) begin
         toggle_in[p] = now;
         buzzer_in    = ~st[0];
         if (nxt >= fdba_pkg::pattern_len(p)) begin
            step_in[p] = 3'd0;
            if ((mode_in == fdba_pkg::MODE_PING) || (mode_in == fdba_pkg::MODE_REMIND)) begin
               mode_in   = fdba_pkg::MODE_IDLE;
               buzzer_in = 1'b0;
            end
         end else begin
            step_in[p] = nxt[2:0];
         end
      end

      if (sq_item.reset_pressed) begin
         if (has_fallen_in) begin
            step_in[fdba_pkg::PAT_PING] = 3'd0;
            mode_in = fdba_pkg::MODE_PING;
         end
         has_fallen_in = 1'b0;
      end

      rsp_in.buzzer_on     = buzzer_in;
      rsp_in.fall_flag     = has_fallen_in;
      rsp_in.freefall_flag = in_freefall_in;
      rsp_in.alert_mode    = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_sample_ff  <= '0;
         last_ff_time_ff <= '0;
         fall_time_ff    <= '0;
         in_freefall_ff  <= 1'b0;
         has_fallen_ff   <= 1'b0;
         mode_ff         <= fdba_pkg::MODE_IDLE;
         buzzer_ff       <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            step_ff[i]   <= 3'd0;
            toggle_ff[i] <= '0;
         end
      end else if (fire) begin
         last_sample_ff  <= last_sample_in;
         last_ff_time_ff <= last_ff_time_in;
         fall_time_ff    <= fall_time_in;
         in_freefall_ff  <= in_freefall_in;
         has_fallen_ff   <= has_fallen_in;
         mode_ff         <= mode_in;
         buzzer_ff       <= buzzer_in;
         for (int i = 0; i < 3; i++) begin
            step_ff[i]   <= step_in[i];
            toggle_ff[i] <= toggle_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_item = rsp_ff;

endmodule

FILE: hdl/fall_detector_with_buzzer_alert_core.sv
// Top level of the fall detector with buzzer alert core.
// Depends on fdba_pkg, fdba_csr, fdba_square, fdba_tracker and the defines header.
//
//   Channel   Direction  Handshake            Contents
//   req_      in         tvalid/tready        one request per loop pass
//   rsp_      out        tvalid/tready        one result per request
//   csr_      in/out     psel/penable/pready  five configuration registers
//
// A request passes an input register, a squaring register and the tracker's
// result register to rsp_tvalid; one request per cycle while rsp_tready is high.
// The tracker state update is combinational and sets the rate.
// Reset is synchronous; valid flags, configuration and tracker state return to their defaults, data registers do not.
// Each stage holds while the stage after it is full and stalled.
`include "fall_detector_with_buzzer_alert_core_defines.svh"

module fall_detector_with_buzzer_alert_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // now_ms[31:0], accel_x[47:32], accel_y[63:48], accel_z[79:64],
   // reset_pressed[80], zero fill [87:81]
   input  logic [87:0] req_tdata,
   // command[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // buzzer_on[0], fall_flag[1], freefall_flag[2], alert_mode[4:3], zero fill [7:5]
   output logic [7:0]  rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   fdba_pkg::cfg_type      cfg;
   fdba_pkg::sq_item_type  sq_item;
   fdba_pkg::rsp_item_type rsp_item;

   logic in_valid_ff, in_valid_in;
   logic sq_valid_ff, sq_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_ready, sq_ready, in_ready;
   logic req_fire, in_adv, sq_adv;

   assign out_ready = !out_valid_ff || rsp_tready;
   assign sq_adv    = sq_valid_ff && out_ready;
   assign sq_ready  = !sq_valid_ff || out_ready;
   assign in_adv    = in_valid_ff && sq_ready;
   assign in_ready  = !in_valid_ff || sq_ready;
   assign req_tready = in_ready;
   assign req_fire  = req_tvalid && in_ready;

   always_comb begin
      in_valid_in  = req_fire ? 1'b1 : (in_adv ? 1'b0 : in_valid_ff);
      sq_valid_in  = in_adv ? 1'b1 : (sq_adv ? 1'b0 : sq_valid_ff);
      out_valid_in = sq_adv ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         sq_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         sq_valid_ff  <= sq_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   fdba_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fdba_square u_square (
      .clock         (clock),
      .load_in       (req_fire),
      .load_sq       (in_adv),
      .now_ms        (req_tdata[31:0]),
      .accel_x       (req_tdata[47:32]),
      .accel_y       (req_tdata[63:48]),
      .accel_z       (req_tdata[79:64]),
      .reset_pressed (req_tdata[80]),
      .command       (req_tuser),
      .sq_item       (sq_item)
   );

   fdba_tracker u_tracker (
      .clock    (clock),
      .reset    (reset),
      .fire     (sq_adv),
      .sq_item  (sq_item),
      .cfg      (cfg),
      .rsp_item (rsp_item)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_item.alert_mode, rsp_item.freefall_flag,
                        rsp_item.fall_flag, rsp_item.buzzer_on};

   `FDBA_ASSERT_NEXT(a_req_lands, clock, reset, req_fire, in_valid_ff)
   `FDBA_ASSERT_NEXT(a_result_lands, clock, reset, sq_adv, out_valid_ff)
   `FDBA_ASSERT_NOW(a_idle_quiet, clock, reset,
      out_valid_ff && (rsp_item.alert_mode == fdba_pkg::MODE_IDLE), !rsp_item.buzzer_on)

endmodule
